// ----- rtl/ladf_pkg.sv -----
package ladf_pkg;

  localparam logic [31:0] MAX_RAW_SIZE_RESET = 32'd67108864;
  localparam int unsigned ACT_DEPTH_DEFAULT = 4;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OK_EARLY   = 3'd1;
  localparam logic [2:0] ST_HDR_SHORT  = 3'd2;
  localparam logic [2:0] ST_OVER_LIMIT = 3'd3;
  localparam logic [2:0] ST_UNSUP      = 3'd4;
  localparam logic [2:0] ST_PAY_SHORT  = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [31:0] entry_index;
    logic [2:0]  status;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic        has_byte;
    logic        is_data;
    logic [7:0]  value;
    logic [31:0] entry_idx;
    logic        has_end;
    logic        has_status;
    logic [2:0]  status;
    logic [31:0] stat_idx;
  } act_t;

endpackage

// ----- rtl/ladf_front.sv -----
module ladf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ladf_pkg::in_item_t in_item,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  output logic              act_push,
  output ladf_pkg::act_t    act
);
  import ladf_pkg::*;

  typedef enum logic [10:0] {
    PH_FLAG  = 11'b000_0000_0001,
    PH_SIZE  = 11'b000_0000_0010,
    PH_COUNT = 11'b000_0000_0100,
    PH_NLEN  = 11'b000_0000_1000,
    PH_NAME  = 11'b000_0001_0000,
    PH_DLEN  = 11'b000_0010_0000,
    PH_DATA  = 11'b000_0100_0000,
    PH_DONE  = 11'b000_1000_0000,
    PH_STOP  = 11'b001_0000_0000,
    PH_OVER  = 11'b010_0000_0000,
    PH_UNSUP = 11'b100_0000_0000
  } phase_t;

  logic [31:0] max_raw_size;
  phase_t      phase, phase_next;
  logic        compressed, compressed_next;
  logic [2:0]  fcnt, fcnt_next;
  logic [31:0] declared, declared_next;
  logic [32:0] raw_offset, raw_offset_next;
  logic [31:0] file_count, file_count_next;
  logic [31:0] entries_done, entries_done_next;
  logic [31:0] field_value, field_value_next;
  logic [31:0] bytes_rem, bytes_rem_next;

  logic [31:0] fv_new;
  logic [2:0]  cnt_new;
  logic [32:0] ro1;
  logic [31:0] ed1;
  logic [31:0] brem1;
  logic        start_stop;
  logic        nlen_over;
  logic        dlen_over;

  always_comb begin
    fv_new     = field_value | (32'(in_item.in_byte) << {fcnt[1:0], 3'b000});
    cnt_new    = fcnt + 3'd1;
    ro1        = raw_offset + 33'd1;
    ed1        = entries_done + 32'd1;
    brem1      = bytes_rem - 32'd1;
    start_stop = ({1'b0, ro1} + 34'd2) > {2'b00, declared};
    nlen_over  = ({1'b0, ro1} + {18'd0, fv_new[15:0]} + 34'd4) > {2'b00, declared};
    dlen_over  = ({1'b0, ro1} + {2'b00, fv_new}) > {2'b00, declared};
  end

  always_comb begin
    phase_next        = phase;
    compressed_next   = compressed;
    fcnt_next         = fcnt;
    declared_next     = declared;
    raw_offset_next   = raw_offset;
    file_count_next   = file_count;
    entries_done_next = entries_done;
    field_value_next  = field_value;
    bytes_rem_next    = bytes_rem;
    act               = '0;
    act.value         = in_item.in_byte;
    act.entry_idx     = entries_done;

    case (phase)
      PH_FLAG: begin
        compressed_next = (in_item.in_byte != 8'd0);
        phase_next      = PH_SIZE;
      end
      PH_SIZE: begin
        field_value_next = fv_new;
        fcnt_next        = cnt_new;
        if (cnt_new == 3'd4) begin
          field_value_next = '0;
          fcnt_next        = '0;
          declared_next    = fv_new;
          raw_offset_next  = '0;
          if (fv_new > max_raw_size) begin
            phase_next = PH_OVER;
          end else if (compressed) begin
            phase_next = PH_UNSUP;
          end else if (fv_new < 32'd4) begin
            phase_next = PH_STOP;
          end else begin
            phase_next = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        raw_offset_next  = ro1;
        field_value_next = fv_new;
        fcnt_next        = cnt_new;
        if (cnt_new == 3'd4) begin
          field_value_next = '0;
          fcnt_next        = '0;
          file_count_next  = fv_new;
          if (fv_new == 32'd0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = start_stop ? PH_STOP : PH_NLEN;
          end
        end
      end
      PH_NLEN: begin
        raw_offset_next  = ro1;
        field_value_next = fv_new;
        fcnt_next        = cnt_new;
        if (cnt_new == 3'd2) begin
          field_value_next = '0;
          fcnt_next        = '0;
          if (nlen_over) begin
            phase_next = PH_STOP;
          end else begin
            bytes_rem_next = {16'd0, fv_new[15:0]};
            phase_next     = (fv_new[15:0] == 16'd0) ? PH_DLEN : PH_NAME;
          end
        end
      end
      PH_NAME: begin
        raw_offset_next = ro1;
        act.has_byte    = 1'b1;
        bytes_rem_next  = brem1;
        if (brem1 == 32'd0) begin
          phase_next = PH_DLEN;
        end
      end
      PH_DLEN: begin
        raw_offset_next  = ro1;
        field_value_next = fv_new;
        fcnt_next        = cnt_new;
        if (cnt_new == 3'd4) begin
          field_value_next = '0;
          fcnt_next        = '0;
          if (dlen_over) begin
            phase_next = PH_STOP;
          end else if (fv_new == 32'd0) begin
            act.has_end       = 1'b1;
            entries_done_next = ed1;
            if (ed1 == file_count) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = start_stop ? PH_STOP : PH_NLEN;
            end
          end else begin
            bytes_rem_next = fv_new;
            phase_next     = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        raw_offset_next = ro1;
        act.has_byte    = 1'b1;
        act.is_data     = 1'b1;
        bytes_rem_next  = brem1;
        if (brem1 == 32'd0) begin
          act.has_end       = 1'b1;
          entries_done_next = ed1;
          if (ed1 == file_count) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = start_stop ? PH_STOP : PH_NLEN;
          end
        end
      end
      PH_DONE, PH_STOP: begin
        if (raw_offset < {1'b0, declared}) begin
          raw_offset_next = ro1;
        end
      end
      default: begin
      end
    endcase

    act.stat_idx   = entries_done_next;
    act.has_status = in_item.in_last;
    if (phase_next inside {PH_FLAG, PH_SIZE}) begin
      act.status = ST_HDR_SHORT;
    end else if (phase_next == PH_OVER) begin
      act.status = ST_OVER_LIMIT;
    end else if (phase_next == PH_UNSUP) begin
      act.status = ST_UNSUP;
    end else if (raw_offset_next < {1'b0, declared_next}) begin
      act.status = ST_PAY_SHORT;
    end else if (phase_next == PH_DONE) begin
      act.status = ST_OK;
    end else begin
      act.status = ST_OK_EARLY;
    end

    act_push = in_valid && (act.has_byte || act.has_end || act.has_status);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_size <= MAX_RAW_SIZE_RESET;
    end else if (cfg_wr_en) begin
      max_raw_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_valid && in_item.in_last)) begin
      phase        <= PH_FLAG;
      compressed   <= 1'b0;
      fcnt         <= '0;
      declared     <= '0;
      raw_offset   <= '0;
      file_count   <= '0;
      entries_done <= '0;
      field_value  <= '0;
      bytes_rem    <= '0;
    end else if (in_valid) begin
      phase        <= phase_next;
      compressed   <= compressed_next;
      fcnt         <= fcnt_next;
      declared     <= declared_next;
      raw_offset   <= raw_offset_next;
      file_count   <= file_count_next;
      entries_done <= entries_done_next;
      field_value  <= field_value_next;
      bytes_rem    <= bytes_rem_next;
    end
  end

endmodule

// ----- rtl/ladf_queue.sv -----
module ladf_queue #(
  parameter int unsigned DEPTH = ladf_pkg::ACT_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ladf_pkg::act_t push_data,
  input  logic           pop,
  output ladf_pkg::act_t head,
  output logic           empty,
  output logic           full
);
  import ladf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  act_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("action queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("action queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("action queue count mismatch");

endmodule

// ----- rtl/ladf_back.sv -----
module ladf_back (
  input  logic                clk,
  input  logic                rst,
  input  ladf_pkg::act_t      head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output ladf_pkg::out_item_t out_item
);
  import ladf_pkg::*;

  act_t      cur, cur_next;
  logic      cur_valid;
  logic      out_valid;
  out_item_t item;
  logic      last_item;
  logic      out_ready;
  logic      step;
  logic      cur_free;

  always_comb begin
    cur_next = cur;
    item     = '0;
    if (cur.has_byte) begin
      item.kind         = cur.is_data ? KIND_DATA : KIND_NAME;
      item.value        = cur.value;
      item.entry_index  = cur.entry_idx;
      last_item         = !(cur.has_end || cur.has_status);
      cur_next.has_byte = 1'b0;
    end else if (cur.has_end) begin
      item.kind        = KIND_END;
      item.entry_index = cur.entry_idx;
      last_item        = !cur.has_status;
      cur_next.has_end = 1'b0;
    end else begin
      item.kind           = KIND_STATUS;
      item.entry_index    = cur.stat_idx;
      item.status         = cur.status;
      last_item           = 1'b1;
      cur_next.has_status = 1'b0;
    end
    item.run_last = last_item;
  end

  assign out_ready = !out_valid || pop;
  assign step      = cur_valid && out_ready;
  assign cur_free  = !cur_valid || (step && last_item);
  assign q_pop     = cur_free && !q_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end else if (step) begin
      cur <= cur_next;
    end
    if (step) begin
      out_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (step && last_item) begin
        cur_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cur_pending: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.has_byte || cur.has_end || cur.has_status))
    else $error("held action has nothing left to send");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == KIND_STATUS) |-> out_item.run_last)
    else $error("packet status not last of its run");

endmodule

// ----- rtl/length_prefixed_archive_deframer.sv -----
// Channel    Handshake            Payload
// input      push / full          in_item (in_byte, in_last)
// result     pop / empty          out_item (kind, value, entry_index, status, run_last)
// config     cfg_wr_en            cfg_wr_data (max_raw_size)
//
// The parser takes one byte per cycle unless full; each byte is classified in the cycle
// it is taken. The result port moves one result per cycle if popped, so a byte that
// yields up to three results holds it for each; the action queue of ACT_DEPTH entries
// absorbs bursts. full rises only while the action queue is full; empty is low while a
// result waits. Synchronous reset, no clearing pass; max_raw_size returns to 64 MiB.
module length_prefixed_archive_deframer #(
  parameter int unsigned ACT_DEPTH = ladf_pkg::ACT_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ladf_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output ladf_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);
  import ladf_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_pop;
  logic act_push;
  act_t act;
  act_t head;

  assign full = q_full;

  ladf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (push && !q_full),
    .in_item    (in_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .act_push   (act_push),
    .act        (act)
  );

  ladf_queue #(
    .DEPTH(ACT_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (act_push),
    .push_data(act),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ladf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule
